[design/spf_pkg.sv]
// shared types and constants for the sample packet framer
// used by spf_front, spf_queue, spf_back and sample_packet_framer
package spf_pkg;

    localparam int TRIPLES_PER_PACKET_DEF = 64;
    localparam int QUEUE_DEPTH_DEF        = 2;

    localparam int SAMPLE_W = 10;
    localparam int BYTE_W   = 8;
    localparam int DELAY_W  = 16;
    localparam int CFG_IDX_W = 8;
    localparam int POS_W    = 5;

    localparam logic [BYTE_W-1:0] START_MARK = 8'hBF;
    localparam logic [BYTE_W-1:0] END_MARK   = 8'hFB;

    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY = 8'd1;

    // byte positions within the work of one item
    localparam logic [POS_W-1:0] POS_START     = 5'd0;
    localparam logic [POS_W-1:0] POS_ID        = 5'd1;
    localparam logic [POS_W-1:0] POS_S0_HI     = 5'd2;
    localparam logic [POS_W-1:0] POS_S0_LO     = 5'd3;
    localparam logic [POS_W-1:0] POS_S1_HI     = 5'd4;
    localparam logic [POS_W-1:0] POS_S1_LO     = 5'd5;
    localparam logic [POS_W-1:0] POS_S2_HI     = 5'd6;
    localparam logic [POS_W-1:0] POS_S2_LO     = 5'd7;
    localparam logic [POS_W-1:0] POS_DELAY_HI  = 5'd8;
    localparam logic [POS_W-1:0] POS_DELAY_LO  = 5'd9;
    localparam logic [POS_W-1:0] POS_PAD_LAST  = 5'd21;
    localparam logic [POS_W-1:0] POS_CHECKSUM  = 5'd22;
    localparam logic [POS_W-1:0] POS_END       = 5'd23;

    typedef struct packed {
        logic                  first;
        logic                  last;
        logic [SAMPLE_W-1:0]   s0;
        logic [SAMPLE_W-1:0]   s1;
        logic [SAMPLE_W-1:0]   s2;
        logic [BYTE_W-1:0]     device_id;
        logic [DELAY_W-1:0]    sample_delay;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[design/sample_packet_framer.sv]
// top level of the sample packet framer: front, job queue and back
// depends on spf_pkg, spf_front, spf_queue, spf_back
//
//  channel   direction  handshake                 payload
//  cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//  samples   in         i_valid/o_stall           i_sample_first/second/third
//  bytes     out        o_valid/i_stall           o_packet_byte, o_packet_end
//
// one byte leaves per cycle unless i_stall or an empty queue holds it; the byte sequencer
// gives a middle triple 6 bytes, the first 8, the last 22 (24 for a one-triple packet)
// a triple is taken at the first edge it is offered while the queue has room
// with the back part idle its first byte passes the queue, then the output register
// the output register holds a byte under i_stall while the front keeps filling the queue
// reset clears counters, queue pointers, checksum and both config registers
module sample_packet_framer #(
    parameter int TRIPLES_PER_PACKET = spf_pkg::TRIPLES_PER_PACKET_DEF,
    parameter int QUEUE_DEPTH        = spf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [spf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spf_pkg::DELAY_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [spf_pkg::SAMPLE_W-1:0]  i_sample_first,
    input  logic [spf_pkg::SAMPLE_W-1:0]  i_sample_second,
    input  logic [spf_pkg::SAMPLE_W-1:0]  i_sample_third,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [spf_pkg::BYTE_W-1:0]    o_packet_byte,
    output logic                          o_packet_end
);

    spf_pkg::t_job      w_push_job;
    spf_pkg::t_job      w_head_job;
    spf_pkg::t_q_status w_q_status;
    logic               w_push;
    logic               w_pop;

    spf_front #(
        .TRIPLES_PER_PACKET(TRIPLES_PER_PACKET)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample_first  (i_sample_first),
        .i_sample_second (i_sample_second),
        .i_sample_third  (i_sample_third),
        .i_q_status      (w_q_status),
        .o_push          (w_push),
        .o_job           (w_push_job)
    );

    spf_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    spf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (w_head_job),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packet_byte (o_packet_byte),
        .o_packet_end  (o_packet_end)
    );

endmodule

[design/spf_front.sv]
// front part: configuration registers, triple counting, job building
// depends on spf_pkg
module spf_front #(
    parameter int TRIPLES_PER_PACKET = spf_pkg::TRIPLES_PER_PACKET_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [spf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spf_pkg::DELAY_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [spf_pkg::SAMPLE_W-1:0]    i_sample_first,
    input  logic [spf_pkg::SAMPLE_W-1:0]    i_sample_second,
    input  logic [spf_pkg::SAMPLE_W-1:0]    i_sample_third,
    input  spf_pkg::t_q_status              i_q_status,
    output logic                            o_push,
    output spf_pkg::t_job                   o_job
);

    localparam int CW = (TRIPLES_PER_PACKET > 1) ? $clog2(TRIPLES_PER_PACKET) : 1;
    localparam logic [CW-1:0] LAST_COUNT = CW'(TRIPLES_PER_PACKET - 1);

    logic [spf_pkg::BYTE_W-1:0]  r_device_id;
    logic [spf_pkg::DELAY_W-1:0] r_sample_delay;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        w_first;
    logic                        w_last;
    logic                        w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = i_q_status.full;
    assign w_accept    = i_valid && !i_q_status.full;
    assign w_first     = (r_count == '0);
    assign w_last      = (r_count == LAST_COUNT);
    assign n_count     = w_last ? '0 : r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id    <= '0;
            r_sample_delay <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == spf_pkg::REG_DEVICE_ID) begin
                r_device_id <= i_cfg_data[spf_pkg::BYTE_W-1:0];
            end else if (i_cfg_index == spf_pkg::REG_SAMPLE_DELAY) begin
                r_sample_delay <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    assign o_push = w_accept;

    always_comb begin
        o_job.first        = w_first;
        o_job.last         = w_last;
        o_job.s0           = i_sample_first;
        o_job.s1           = i_sample_second;
        o_job.s2           = i_sample_third;
        o_job.device_id    = r_device_id;
        o_job.sample_delay = r_sample_delay;
    end

endmodule

[design/spf_queue.sv]
// short job queue between the front and back parts
// depends on spf_pkg
module spf_queue #(
    parameter int QUEUE_DEPTH = spf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  spf_pkg::t_job      i_job,
    input  logic               i_pop,
    output spf_pkg::t_job      o_job,
    output spf_pkg::t_q_status o_status
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(QUEUE_DEPTH);

    spf_pkg::t_job r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_fill;
    logic [NW-1:0] n_fill;

    always_comb begin
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_fill <= n_fill;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_fill == FULL_CNT);
    assign o_status.empty = (r_fill == '0);

endmodule

[design/spf_back.sv]
// back part: byte sequencer, running checksum and output register
// depends on spf_pkg
module spf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spf_pkg::t_job                 i_job,
    input  spf_pkg::t_q_status            i_q_status,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [spf_pkg::BYTE_W-1:0]    o_packet_byte,
    output logic                          o_packet_end
);

    logic                         r_busy;
    logic [spf_pkg::POS_W-1:0]    r_pos;
    logic [spf_pkg::BYTE_W-1:0]   r_sum;
    logic                         r_out_valid;
    logic [spf_pkg::BYTE_W-1:0]   r_out_byte;
    logic                         r_out_end;

    logic                         w_advance;
    logic                         w_fire;
    logic                         w_done;
    logic [spf_pkg::POS_W-1:0]    w_pos;
    logic [spf_pkg::BYTE_W-1:0]   w_byte;
    logic [spf_pkg::BYTE_W-1:0]   w_check;

    assign w_advance = !r_out_valid || !i_stall;
    assign w_fire    = w_advance && !i_q_status.empty;
    assign w_pos     = r_busy ? r_pos
                     : (i_job.first ? spf_pkg::POS_START : spf_pkg::POS_S0_HI);
    assign w_done    = (w_pos == spf_pkg::POS_S2_LO && !i_job.last)
                     || (w_pos == spf_pkg::POS_END);
    assign o_pop     = w_fire && w_done;
    assign w_check   = r_sum + spf_pkg::END_MARK;

    always_comb begin
        case (w_pos)
            spf_pkg::POS_START:    w_byte = spf_pkg::START_MARK;
            spf_pkg::POS_ID:       w_byte = i_job.device_id;
            spf_pkg::POS_S0_HI:    w_byte = {6'b0, i_job.s0[9:8]};
            spf_pkg::POS_S0_LO:    w_byte = i_job.s0[7:0];
            spf_pkg::POS_S1_HI:    w_byte = {6'b0, i_job.s1[9:8]};
            spf_pkg::POS_S1_LO:    w_byte = i_job.s1[7:0];
            spf_pkg::POS_S2_HI:    w_byte = {6'b0, i_job.s2[9:8]};
            spf_pkg::POS_S2_LO:    w_byte = i_job.s2[7:0];
            spf_pkg::POS_DELAY_HI: w_byte = i_job.sample_delay[15:8];
            spf_pkg::POS_DELAY_LO: w_byte = i_job.sample_delay[7:0];
            spf_pkg::POS_CHECKSUM: w_byte = w_check;
            spf_pkg::POS_END:      w_byte = spf_pkg::END_MARK;
            default:               w_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= !i_q_status.empty;
            end
            if (w_fire) begin
                r_busy <= !w_done;
                r_pos  <= w_pos + 1'b1;
                if (w_pos == spf_pkg::POS_START) begin
                    r_sum <= w_byte;
                end else if (w_pos < spf_pkg::POS_CHECKSUM) begin
                    r_sum <= r_sum + w_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_byte <= w_byte;
            r_out_end  <= (w_pos == spf_pkg::POS_END);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_packet_byte = r_out_byte;
    assign o_packet_end  = r_out_end;

`ifndef SYNTHESIS
    a_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> (r_out_byte == spf_pkg::END_MARK))
        else $error("end flag on a byte other than the end mark");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos != spf_pkg::POS_START && r_pos <= spf_pkg::POS_END))
        else $error("byte position out of range while busy");

    a_busy_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_q_status.empty)
        else $error("busy with no job in the queue");

    a_trailer_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_pos > spf_pkg::POS_S2_LO) |-> i_job.last)
        else $error("trailer bytes for a job that does not end a packet");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// testbench for sample_packet_framer: directed and random triples in, framed bytes checked against a predictor
// depends on spf_pkg and the sample_packet_framer rtl
module tb;

    localparam int TRIPLES        = spf_pkg::TRIPLES_PER_PACKET_DEF;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 48;
    localparam int SETTLE         = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;

    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [spf_pkg::SAMPLE_W-1:0] s0;
        logic [spf_pkg::SAMPLE_W-1:0] s1;
        logic [spf_pkg::SAMPLE_W-1:0] s2;
    } t_triple;

    typedef struct packed {
        logic [spf_pkg::BYTE_W-1:0] data;
        logic                       last;
    } t_out_byte;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [spf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [spf_pkg::DELAY_W-1:0]   i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [spf_pkg::SAMPLE_W-1:0]  i_sample_first = '0;
    logic [spf_pkg::SAMPLE_W-1:0]  i_sample_second = '0;
    logic [spf_pkg::SAMPLE_W-1:0]  i_sample_third = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [spf_pkg::BYTE_W-1:0]    o_packet_byte;
    logic                          o_packet_end;

    t_triple    pending_triples[$];
    t_out_byte  exp_bytes[$];
    t_idle_mode idle_mode = IDLE_NONE;

    logic [spf_pkg::BYTE_W-1:0]  model_dev_id = '0;
    logic [spf_pkg::DELAY_W-1:0] model_delay = '0;
    int                          pkt_triples = 0;
    logic [spf_pkg::BYTE_W-1:0]  pkt_sum = '0;

    int   err_count = 0;
    int   hold_left = 0;
    bit   hold_req = 1'b0;
    bit   hold_seen = 1'b0;
    int   quiet_cycles = 0;

    sample_packet_framer #(
        .TRIPLES_PER_PACKET(TRIPLES)
    ) uut (.*);

    always #6 i_clk = ~i_clk;

    function automatic bit roll_idle(input bit rx_side);
        int p;
        p = $urandom_range(99);
        case (idle_mode)
            IDLE_TX:   return !rx_side && p < 54;
            IDLE_RX:   return rx_side && p < 54;
            IDLE_BOTH: return p < 38;
            default:   return 1'b0;
        endcase
    endfunction

    task automatic push_byte(input logic [spf_pkg::BYTE_W-1:0] b, input logic last);
        exp_bytes.push_back('{data: b, last: last});
    endtask

    task automatic push_summed(input logic [spf_pkg::BYTE_W-1:0] b);
        pkt_sum = pkt_sum + b;
        push_byte(b, 1'b0);
    endtask

    task automatic frame_triple(input t_triple t);
        logic [spf_pkg::SAMPLE_W-1:0] smp[3];
        logic [15:0]                  w;
        smp[0] = t.s0;
        smp[1] = t.s1;
        smp[2] = t.s2;
        if (pkt_triples == 0) begin
            pkt_sum = '0;
            push_summed(spf_pkg::START_MARK);
            push_summed(model_dev_id);
        end
        for (int i = 0; i < 3; i++) begin
            w = {6'b0, smp[i]};
            push_summed(w[15:8]);
            push_summed(w[7:0]);
        end
        if (pkt_triples + 1 >= TRIPLES) begin
            push_summed(model_delay[15:8]);
            push_summed(model_delay[7:0]);
            for (int i = 0; i < 12; i++)
                push_summed(8'h00);
            pkt_sum = pkt_sum + spf_pkg::END_MARK;
            push_byte(pkt_sum, 1'b0);
            push_byte(spf_pkg::END_MARK, 1'b1);
            pkt_triples = 0;
            pkt_sum = '0;
        end else begin
            pkt_triples++;
        end
    endtask

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // sample driver
    always @(posedge i_clk) begin
        bit      busy;
        t_triple t;
        busy = i_valid;
        if (i_valid && !o_stall) begin
            frame_triple('{s0: i_sample_first, s1: i_sample_second, s2: i_sample_third});
            busy = 1'b0;
        end
        if (!busy) begin
            if (i_rst_n && pending_triples.size() != 0 && !roll_idle(1'b0)) begin
                t = pending_triples.pop_front();
                i_sample_first  <= t.s0;
                i_sample_second <= t.s1;
                i_sample_third  <= t.s2;
                i_valid         <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // byte monitor and receiver stall
    always @(posedge i_clk) begin
        t_out_byte want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (exp_bytes.size() == 0) begin
                flag_error($sformatf("unexpected byte %02h end %0b", o_packet_byte,
                                     o_packet_end));
            end else begin
                want = exp_bytes.pop_front();
                if (o_packet_byte !== want.data || o_packet_end !== want.last)
                    flag_error($sformatf("byte exp %02h got %02h, end exp %0b got %0b",
                                         want.data, o_packet_byte, want.last, o_packet_end));
            end
        end
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
        i_stall <= (hold_left > 0) || roll_idle(1'b1);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [spf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [spf_pkg::DELAY_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == spf_pkg::REG_DEVICE_ID)
            model_dev_id = data[spf_pkg::BYTE_W-1:0];
        else if (idx == spf_pkg::REG_SAMPLE_DELAY)
            model_delay = data;
    endtask

    task automatic queue_triple(input logic [spf_pkg::SAMPLE_W-1:0] a,
                                input logic [spf_pkg::SAMPLE_W-1:0] b,
                                input logic [spf_pkg::SAMPLE_W-1:0] c);
        pending_triples.push_back('{s0: a, s1: b, s2: c});
    endtask

    function automatic logic [spf_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return spf_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic drain();
        while (pending_triples.size() != 0 || i_valid || exp_bytes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin
        logic [spf_pkg::DELAY_W-1:0] dev_data;
        logic [spf_pkg::DELAY_W-1:0] dly_data;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // id write carries junk in the upper bits
        write_reg(spf_pkg::REG_DEVICE_ID, 16'hA5FF);
        write_reg(spf_pkg::REG_SAMPLE_DELAY, 16'hFFFF);
        write_reg(8'hFF, 16'h1234);
        write_reg(8'h02, 16'h00AA);
        @(negedge i_clk);

        queue_triple(10'h000, 10'h000, 10'h000);
        queue_triple(10'h3FF, 10'h3FF, 10'h3FF);
        queue_triple(10'h3FF, 10'h000, 10'h000);
        queue_triple(10'h000, 10'h3FF, 10'h000);
        queue_triple(10'h000, 10'h000, 10'h3FF);
        queue_triple(10'h2AA, 10'h155, 10'h2AA);
        queue_triple(10'h155, 10'h2AA, 10'h155);
        queue_triple(10'h001, 10'h002, 10'h003);
        queue_triple(10'h200, 10'h100, 10'h0FF);
        queue_triple(10'h300, 10'h3FF, 10'h001);
        queue_triple(10'h0BF, 10'h0FB, 10'h1FB);
        queue_triple(10'h3FE, 10'h201, 10'h080);
        for (int i = 0; i < 13; i++)
            queue_triple(rand_sample(), rand_sample(), rand_sample());

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p % 4)
                0: begin
                    dev_data = 16'h0000;
                    dly_data = 16'h0000;
                end
                1: begin
                    dev_data = 16'hFFFF;
                    dly_data = 16'hFFFF;
                end
                default: begin
                    dev_data = spf_pkg::DELAY_W'($urandom);
                    dly_data = spf_pkg::DELAY_W'($urandom);
                end
            endcase
            write_reg(spf_pkg::REG_DEVICE_ID, dev_data);
            write_reg(spf_pkg::REG_SAMPLE_DELAY, dly_data);
            write_reg(spf_pkg::CFG_IDX_W'($urandom_range(255, 2)),
                      spf_pkg::DELAY_W'($urandom));
            @(negedge i_clk);
            idle_mode = t_idle_mode'(p % 4);
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_triple(rand_sample(), rand_sample(), rand_sample());
            if (p == 0 || p == 5)
                hold_req = !hold_req;
        end
        drain();

        if (err_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
